@@ hw/rtl/rrs_pkg.sv @@
package rrs_pkg;

  localparam int TRIG_BITS = 18;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SINE   = 3'd0,
    REG_COSINE = 3'd1,
    REG_CTR_X  = 3'd2,
    REG_CTR_Y  = 3'd3,
    REG_NEAR_X = 3'd4,
    REG_NEAR_Y = 3'd5,
    REG_FAR_X  = 3'd6,
    REG_FAR_Y  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] ALPHA_OPAQUE = 2'b11;

  // old frame buffer byte and fill color riding along the pipe
  typedef struct packed {
    logic [7:0] old_px;
    logic [7:0] fill;
  } pix_t;

endpackage

@@ hw/rtl/rrs_rotate.sv @@
module rrs_rotate import rrs_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_col,
  input  logic signed [COORD_BITS-1:0]       in_row,
  input  pix_t                               in_pix,
  input  logic signed [TRIG_BITS-1:0]        sine,
  input  logic signed [TRIG_BITS-1:0]        cosine,
  input  logic signed [COORD_BITS-1:0]       center_x,
  input  logic signed [COORD_BITS-1:0]       center_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_BITS+TRIG_BITS+1:0] out_rx,
  output logic signed [COORD_BITS+TRIG_BITS+1:0] out_ry,
  output pix_t                               out_pix
);

  localparam int DXW = COORD_BITS + 1;
  localparam int PW  = DXW + TRIG_BITS;
  localparam int RW  = PW + 1;

  // stage a: offset from pivot
  logic                  va_r;
  logic signed [DXW-1:0] dx_r, dy_r;
  pix_t                  pa_r;
  // stage b: four products
  logic                  vb_r;
  logic signed [PW-1:0]  pxc_r, pys_r, pyc_r, pxs_r;
  pix_t                  pb_r;
  // stage c: rotated offset
  logic                  vc_r;
  logic signed [RW-1:0]  rx_r, ry_r;
  pix_t                  pc_r;

  logic rdy_a, rdy_b, rdy_c;
  logic signed [DXW-1:0] dx_nxt, dy_nxt;
  logic signed [PW-1:0]  pxc_nxt, pys_nxt, pyc_nxt, pxs_nxt;
  logic signed [RW-1:0]  rx_nxt, ry_nxt;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    dx_nxt  = $signed(DXW'(in_col)) - $signed(DXW'(center_x));
    dy_nxt  = $signed(DXW'(in_row)) - $signed(DXW'(center_y));
    pxc_nxt = $signed(PW'(dx_r)) * $signed(PW'(cosine));
    pys_nxt = $signed(PW'(dy_r)) * $signed(PW'(sine));
    pyc_nxt = $signed(PW'(dy_r)) * $signed(PW'(cosine));
    pxs_nxt = $signed(PW'(dx_r)) * $signed(PW'(sine));
    rx_nxt  = $signed(RW'(pxc_r)) + $signed(RW'(pys_r));
    ry_nxt  = $signed(RW'(pyc_r)) - $signed(RW'(pxs_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      pa_r <= in_pix;
    end
    if (rdy_b && va_r) begin
      pxc_r <= pxc_nxt;
      pys_r <= pys_nxt;
      pyc_r <= pyc_nxt;
      pxs_r <= pxs_nxt;
      pb_r  <= pa_r;
    end
    if (rdy_c && vb_r) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      pc_r <= pb_r;
    end
  end

  assign out_valid = vc_r;
  assign out_rx    = rx_r;
  assign out_ry    = ry_r;
  assign out_pix   = pc_r;

endmodule

@@ hw/rtl/rrs_edge.sv @@
module rrs_edge import rrs_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int UNIT_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_BITS+TRIG_BITS+1:0] in_rx,
  input  logic signed [COORD_BITS+TRIG_BITS+1:0] in_ry,
  input  pix_t                                   in_pix,
  input  logic signed [COORD_BITS-1:0]           near_x,
  input  logic signed [COORD_BITS-1:0]           near_y,
  input  logic signed [COORD_BITS-1:0]           far_x,
  input  logic signed [COORD_BITS-1:0]           far_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_inside,
  output logic                                   out_deep,
  output logic [UNIT_BITS:0]                     out_weight,
  output pix_t                                   out_pix
);

  localparam int RW = COORD_BITS + TRIG_BITS + 2;
  localparam int DW = RW + 1;
  localparam logic signed [DW-1:0] UnitD = DW'(64'd1 << UNIT_BITS);

  // stage d: edge distances
  logic                 vd_r;
  logic signed [DW-1:0] d1_r, d2_r, d3_r, d4_r;
  pix_t                 pd_r;
  // stage e: outside test, pairwise minimum
  logic                 ve_r;
  logic                 out_e_r;
  logic signed [DW-1:0] m12_r, m34_r;
  pix_t                 pe_r;
  // stage f: final minimum, border weight
  logic                 vf_r;
  logic                 inside_r, deep_r;
  logic [UNIT_BITS:0]   wt_r;
  pix_t                 pf_r;

  logic rdy_d, rdy_e, rdy_f;
  logic signed [DW-1:0] d1_nxt, d2_nxt, d3_nxt, d4_nxt;
  logic signed [DW-1:0] m12_nxt, m34_nxt, dmin;
  logic                 out_e_nxt;

  assign rdy_f    = !vf_r || out_ready;
  assign rdy_e    = !ve_r || rdy_f;
  assign rdy_d    = !vd_r || rdy_e;
  assign in_ready = rdy_d;

  always_comb begin
    d1_nxt    = $signed(DW'(in_rx)) - ($signed(DW'(near_x)) <<< UNIT_BITS);
    d2_nxt    = ($signed(DW'(far_x)) <<< UNIT_BITS) - $signed(DW'(in_rx));
    d3_nxt    = $signed(DW'(in_ry)) - ($signed(DW'(near_y)) <<< UNIT_BITS);
    d4_nxt    = ($signed(DW'(far_y)) <<< UNIT_BITS) - $signed(DW'(in_ry));
    out_e_nxt = d1_r[DW-1] || d2_r[DW-1] || d3_r[DW-1] || d4_r[DW-1];
    m12_nxt   = (d1_r < d2_r) ? d1_r : d2_r;
    m34_nxt   = (d3_r < d4_r) ? d3_r : d4_r;
    dmin      = (m12_r < m34_r) ? m12_r : m34_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_d) vd_r <= in_valid;
      if (rdy_e) ve_r <= vd_r;
      if (rdy_f) vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && in_valid) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      d3_r <= d3_nxt;
      d4_r <= d4_nxt;
      pd_r <= in_pix;
    end
    if (rdy_e && vd_r) begin
      out_e_r <= out_e_nxt;
      m12_r   <= m12_nxt;
      m34_r   <= m34_nxt;
      pe_r    <= pd_r;
    end
    if (rdy_f && ve_r) begin
      inside_r <= !out_e_r;
      deep_r   <= dmin > UnitD;
      wt_r     <= dmin[UNIT_BITS:0];
      pf_r     <= pe_r;
    end
  end

  assign out_valid  = vf_r;
  assign out_inside = inside_r;
  assign out_deep   = deep_r;
  assign out_weight = wt_r;
  assign out_pix    = pf_r;

endmodule

@@ hw/rtl/rrs_blend.sv @@
module rrs_blend import rrs_pkg::*; #(
  parameter int UNIT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_inside,
  input  logic               in_deep,
  input  logic [UNIT_BITS:0] in_weight,
  input  pix_t               in_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_new_pixel,
  output logic               out_write_flag
);

  localparam int SW = UNIT_BITS + 3;
  localparam logic [SW-1:0] UnitS = SW'(64'd1 << UNIT_BITS);
  localparam logic [SW-1:0] HalfS = SW'(64'd1 << (UNIT_BITS - 1));

  logic       v_r;
  logic [7:0] px_r;
  logic       wf_r;
  logic [7:0] px_nxt;
  logic [SW-1:0] wa, wb;

  function automatic logic [1:0] mix(input logic [1:0] oldc, input logic [1:0] newc,
                                     input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] acc;
    acc = SW'(newc) * a + SW'(oldc) * b + HalfS;
    return acc[UNIT_BITS +: 2];
  endfunction

  assign in_ready = !v_r || out_ready;

  always_comb begin
    wa = SW'(in_weight);
    wb = UnitS - wa;
    if (!in_inside) begin
      px_nxt = 8'h00;
    end else if (in_deep) begin
      px_nxt = in_pix.fill;
    end else begin
      px_nxt = {ALPHA_OPAQUE,
                mix(in_pix.old_px[5:4], in_pix.fill[5:4], wa, wb),
                mix(in_pix.old_px[3:2], in_pix.fill[3:2], wa, wb),
                mix(in_pix.old_px[1:0], in_pix.fill[1:0], wa, wb)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      px_r <= px_nxt;
      wf_r <= in_inside;
    end
  end

  assign out_valid      = v_r;
  assign out_new_pixel  = px_r;
  assign out_write_flag = wf_r;

endmodule

@@ hw/rtl/rotated_rect_antialias_shader.sv @@
// channel  direction  handshake            word
// in_      input      in_valid/in_ready    pixel_col, pixel_row, old_pixel, fill_color
// out_     output     out_valid/out_ready  new_pixel, write_flag
// cfg_     input      cfg_we               cfg_index, cfg_data
//
// One pixel per cycle while out_ready is high; stages: offset, multiply,
// rotate, distance, pair min, final min, blend. Each stage holds its word
// while the next is full and stalled; bubbles collapse. Synchronous active-low
// reset clears the valid bits and loads the register defaults (cosine = unit scale).
module rotated_rect_antialias_shader import rrs_pkg::*; #(
  parameter int UNIT_SCALE = 65536,
  parameter int COORD_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_pixel_col,
  input  logic signed [COORD_BITS-1:0]  in_pixel_row,
  input  logic [7:0]                    in_old_pixel,
  input  logic [7:0]                    in_fill_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_new_pixel,
  output logic                          out_write_flag,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [TRIG_BITS-1:0]          cfg_data
);

  localparam int UNIT_BITS = $clog2(UNIT_SCALE);
  localparam int RW        = COORD_BITS + TRIG_BITS + 2;

  logic signed [TRIG_BITS-1:0]  sine_r, cosine_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r, nx_r, ny_r, fx_r, fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sine_r   <= '0;
      cosine_r <= TRIG_BITS'(UNIT_SCALE);
      cx_r     <= '0;
      cy_r     <= '0;
      nx_r     <= '0;
      ny_r     <= '0;
      fx_r     <= '0;
      fy_r     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SINE:   sine_r   <= cfg_data;
        REG_COSINE: cosine_r <= cfg_data;
        REG_CTR_X:  cx_r     <= cfg_data[COORD_BITS-1:0];
        REG_CTR_Y:  cy_r     <= cfg_data[COORD_BITS-1:0];
        REG_NEAR_X: nx_r     <= cfg_data[COORD_BITS-1:0];
        REG_NEAR_Y: ny_r     <= cfg_data[COORD_BITS-1:0];
        REG_FAR_X:  fx_r     <= cfg_data[COORD_BITS-1:0];
        REG_FAR_Y:  fy_r     <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  pix_t                 in_pix;
  logic                 rot_valid, rot_ready;
  logic signed [RW-1:0] rot_rx, rot_ry;
  pix_t                 rot_pix;
  logic                 edg_valid, edg_ready, edg_inside, edg_deep;
  logic [UNIT_BITS:0]   edg_weight;
  pix_t                 edg_pix;

  assign in_pix.old_px = in_old_pixel;
  assign in_pix.fill   = in_fill_color;

  rrs_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_col    (in_pixel_col),
    .in_row    (in_pixel_row),
    .in_pix    (in_pix),
    .sine      (sine_r),
    .cosine    (cosine_r),
    .center_x  (cx_r),
    .center_y  (cy_r),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_rx    (rot_rx),
    .out_ry    (rot_ry),
    .out_pix   (rot_pix)
  );

  rrs_edge #(.COORD_BITS(COORD_BITS), .UNIT_BITS(UNIT_BITS)) u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rot_valid),
    .in_ready   (rot_ready),
    .in_rx      (rot_rx),
    .in_ry      (rot_ry),
    .in_pix     (rot_pix),
    .near_x     (nx_r),
    .near_y     (ny_r),
    .far_x      (fx_r),
    .far_y      (fy_r),
    .out_valid  (edg_valid),
    .out_ready  (edg_ready),
    .out_inside (edg_inside),
    .out_deep   (edg_deep),
    .out_weight (edg_weight),
    .out_pix    (edg_pix)
  );

  rrs_blend #(.UNIT_BITS(UNIT_BITS)) u_blend (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (edg_valid),
    .in_ready       (edg_ready),
    .in_inside      (edg_inside),
    .in_deep        (edg_deep),
    .in_weight      (edg_weight),
    .in_pix         (edg_pix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_new_pixel  (out_new_pixel),
    .out_write_flag (out_write_flag)
  );

endmodule
